[hw/rtl/dlasd_pkg.sv]
// ----------------------------------------------------------------------------
// dlasd_pkg: shared types and constants for the decimal limb add/sub/divide
// Field widths, unit command and status bundles, operation codes and the
// power-of-ten modulus lookup.
// ----------------------------------------------------------------------------
package dlasd_pkg;

  localparam int WORD_W          = 32;
  localparam int DIV_W           = 64;
  localparam int DIGIT_W         = 4;
  localparam int MAX_LIMB_DIGITS = 9;
  localparam int FALLBACK_DIGITS = 4;
  localparam int RESET_DIGITS    = 4;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIV  = 2'd2,
    OP_NONE = 2'd3
  } dlasd_op_e;

  typedef struct packed {
    logic               start;
    logic [DIGIT_W-1:0] digits;
  } dlasd_scale_cmd_t;

  typedef struct packed {
    logic start;
    logic half;   // integer part: 32 dividend bits only
  } dlasd_div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dlasd_unit_stat_t;

  // Ten to the given power, for digit counts 0 to 9.
  function automatic logic [WORD_W-1:0] pow10_f(input logic [DIGIT_W-1:0] digits);
    logic [WORD_W-1:0] m;
    case (digits)
      4'd0:    m = 32'd1;
      4'd1:    m = 32'd10;
      4'd2:    m = 32'd100;
      4'd3:    m = 32'd1000;
      4'd4:    m = 32'd10000;
      4'd5:    m = 32'd100000;
      4'd6:    m = 32'd1000000;
      4'd7:    m = 32'd10000000;
      4'd8:    m = 32'd100000000;
      4'd9:    m = 32'd1000000000;
      default: m = 32'd10000;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/decimal_limb_add_sub_div_top.sv]
// ----------------------------------------------------------------------------
// decimal_limb_add_sub_div_top: streaming base-10^k limb add/sub/divide
// Adds, subtracts or divides by a word fixed-point decimal numbers, one limb
// pair per beat, carrying carry/borrow or remainder between limbs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o | req_type, operands, int_part,
//          |           |                        | last
//  out     | source    | out_valid_o/out_stall_i | result_limb, result_last,
//          |           |                        | all_zero, div_error
//  cfg     | sink      | cfg_we_i               | cfg_wdata_i (limb digits)
//
//  An accepted beat is latched in ST_IDLE and decoded in ST_ARITH. Add/sub
//  of the integer part is registered there; a fractional limb goes through
//  ST_FIX. A divide of the integer part runs 32 divider bits in ST_DIV; a
//  fractional limb first takes k times-ten steps in the scaler, where k is
//  the digit count, then 64 divider bits. The next beat is taken only after
//  the result is committed, so the bit-serial divider sets the rate of divides.
//  Reset is asynchronous, active low; it clears carry and remainder, sets the
//  zero flag and sets the digit count to 4. A stalled result holds in the
//  output register while the next beat is already in work.
// ----------------------------------------------------------------------------
module decimal_limb_add_sub_div_top #(
  parameter int MaxLimbDigits = dlasd_pkg::MAX_LIMB_DIGITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [dlasd_pkg::DIGIT_W-1:0]      cfg_wdata_i,
  // input beats
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic [dlasd_pkg::WORD_W-1:0]       operand_a_i,
  input  logic [dlasd_pkg::WORD_W-1:0]       operand_b_i,
  input  logic                               int_part_i,
  input  logic                               last_i,
  // result beats
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dlasd_pkg::WORD_W-1:0]       result_limb_o,
  output logic                               result_last_o,
  output logic                               all_zero_o,
  output logic                               div_error_o
);
  import dlasd_pkg::*;

  // width of the largest modulus the digit range allows
  localparam int ModW = $clog2(pow10_f(DIGIT_W'(MaxLimbDigits)) + 1);
  localparam int WrkW = WORD_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARITH,
    ST_FIX,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [DIGIT_W-1:0] digits_q, digits_d;
  dlasd_op_e          op_q, op_d;
  logic [WORD_W-1:0]  a_q, a_d;
  logic [WORD_W-1:0]  b_q, b_d;
  logic               ip_q, ip_d;
  logic               last_q, last_d;
  logic [WrkW-1:0]    work_q, work_d;
  logic [WORD_W-1:0]  res_q, res_d;
  logic               err_q, err_d;
  logic               upd_q, upd_d;
  logic               cb_q, cb_d;
  logic [WORD_W-1:0]  rem_q, rem_d;
  logic               zero_q, zero_d;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  out_limb_q, out_limb_d;
  logic               out_last_q, out_last_d;
  logic               out_zero_q, out_zero_d;
  logic               out_err_q, out_err_d;

  logic [DIGIT_W-1:0] eff_digits;
  logic [ModW-1:0]    modulus;
  logic [WrkW-1:0]    sum_w, diff_w, over_w;
  logic [WORD_W-1:0]  sub_fix;
  logic               zero_next;
  logic               out_free;
  logic               accept;

  dlasd_scale_cmd_t   scale_cmd;
  dlasd_unit_stat_t   scale_stat;
  logic [DIV_W-1:0]   scale_prod;
  dlasd_div_cmd_t     div_cmd;
  dlasd_unit_stat_t   div_stat;
  logic [DIV_W-1:0]   div_dividend;
  logic [WORD_W-1:0]  div_quot;
  logic [WORD_W-1:0]  div_rem;

  // out-of-range digit counts fall back to four digits
  assign eff_digits = ((digits_q == '0) || (digits_q > DIGIT_W'(MaxLimbDigits))) ?
                      DIGIT_W'(FALLBACK_DIGITS) : digits_q;
  assign modulus    = ModW'(pow10_f(eff_digits));

  assign sum_w   = {2'b00, a_q} + {2'b00, b_q} + {{(WrkW-1){1'b0}}, cb_q};
  assign diff_w  = {2'b00, a_q} - {2'b00, b_q} - {{(WrkW-1){1'b0}}, cb_q};
  assign over_w  = work_q - {{(WrkW-ModW){1'b0}}, modulus};
  assign sub_fix = work_q[WORD_W-1:0] + {{(WORD_W-ModW){1'b0}}, modulus};

  assign zero_next = zero_q & ~(upd_q & (res_q != '0));
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // integer part divides its own word; a fractional limb adds the scaled remainder
  assign div_dividend = (state_q == ST_SCALE) ?
                        scale_prod + {{(DIV_W-WORD_W){1'b0}}, a_q} :
                        {a_q, {(DIV_W-WORD_W){1'b0}}};

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    ip_d        = ip_q;
    last_d      = last_q;
    work_d      = work_q;
    res_d       = res_q;
    err_d       = err_q;
    upd_d       = upd_q;
    cb_d        = cb_q;
    rem_d       = rem_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_limb_d  = out_limb_q;
    out_last_d  = out_last_q;
    out_zero_d  = out_zero_q;
    out_err_d   = out_err_q;
    scale_cmd   = '0;
    div_cmd     = '0;

    if (cfg_we_i) begin
      digits_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        // latch the beat and decode it next cycle
        if (accept) begin
          op_d    = dlasd_op_e'(req_type_i);
          a_d     = operand_a_i;
          b_d     = operand_b_i;
          ip_d    = int_part_i;
          last_d  = last_i;
          state_d = ST_ARITH;
        end
      end
      ST_ARITH: begin
        err_d = 1'b0;
        upd_d = 1'b1;
        res_d = '0;
        case (op_q)
          OP_ADD: begin
            if (ip_q) begin
              // integer part wraps and swallows the carry
              res_d   = sum_w[WORD_W-1:0];
              cb_d    = 1'b0;
              state_d = ST_DONE;
            end else begin
              work_d  = sum_w;
              state_d = ST_FIX;
            end
          end
          OP_SUB: begin
            if (ip_q) begin
              res_d   = diff_w[WORD_W-1:0];
              cb_d    = 1'b0;
              state_d = ST_DONE;
            end else begin
              work_d  = diff_w;
              state_d = ST_FIX;
            end
          end
          OP_DIV: begin
            if (b_q == '0) begin
              // zero divisor: flag it, result and remainder drop to zero
              err_d   = 1'b1;
              rem_d   = '0;
              state_d = ST_DONE;
            end else if (ip_q) begin
              div_cmd.start = 1'b1;
              div_cmd.half  = 1'b1;
              state_d       = ST_DIV;
            end else begin
              scale_cmd.start  = 1'b1;
              scale_cmd.digits = eff_digits;
              state_d          = ST_SCALE;
            end
          end
          default: begin
            // unused code: no arithmetic, zero flag untouched
            upd_d   = 1'b0;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_FIX: begin
        if (op_q == OP_ADD) begin
          // subtract the modulus at most once
          if (!over_w[WrkW-1]) begin
            res_d = over_w[WORD_W-1:0];
            cb_d  = 1'b1;
          end else begin
            res_d = work_q[WORD_W-1:0];
            cb_d  = 1'b0;
          end
        end else begin
          // negative difference: borrow from the next limb
          if (work_q[WrkW-1]) begin
            res_d = sub_fix;
            cb_d  = 1'b1;
          end else begin
            res_d = work_q[WORD_W-1:0];
            cb_d  = 1'b0;
          end
        end
        state_d = ST_DONE;
      end
      ST_SCALE: begin
        if (scale_stat.done) begin
          div_cmd.start = 1'b1;
          div_cmd.half  = 1'b0;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_d   = div_quot;
          rem_d   = div_rem;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free, then commit the beat
        if (out_free) begin
          out_valid_d = 1'b1;
          out_limb_d  = res_q;
          out_last_d  = last_q;
          out_zero_d  = zero_next;
          out_err_d   = err_q;
          if (last_q) begin
            cb_d   = 1'b0;
            rem_d  = '0;
            zero_d = 1'b1;
          end else begin
            zero_d = zero_next;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      digits_q    <= DIGIT_W'(RESET_DIGITS);
      op_q        <= OP_NONE;
      a_q         <= '0;
      b_q         <= '0;
      ip_q        <= 1'b0;
      last_q      <= 1'b0;
      work_q      <= '0;
      res_q       <= '0;
      err_q       <= 1'b0;
      upd_q       <= 1'b0;
      cb_q        <= 1'b0;
      rem_q       <= '0;
      zero_q      <= 1'b1;
      out_valid_q <= 1'b0;
      out_limb_q  <= '0;
      out_last_q  <= 1'b0;
      out_zero_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      digits_q    <= digits_d;
      op_q        <= op_d;
      a_q         <= a_d;
      b_q         <= b_d;
      ip_q        <= ip_d;
      last_q      <= last_d;
      work_q      <= work_d;
      res_q       <= res_d;
      err_q       <= err_d;
      upd_q       <= upd_d;
      cb_q        <= cb_d;
      rem_q       <= rem_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
      out_limb_q  <= out_limb_d;
      out_last_q  <= out_last_d;
      out_zero_q  <= out_zero_d;
      out_err_q   <= out_err_d;
    end
  end

  dlasd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (scale_cmd),
    .value_i (rem_q),
    .stat_o  (scale_stat),
    .prod_o  (scale_prod)
  );

  dlasd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i (div_dividend),
    .divisor_i  (b_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_valid_o   = out_valid_q;
  assign result_limb_o = out_limb_q;
  assign result_last_o = out_last_q;
  assign all_zero_o    = out_zero_q;
  assign div_error_o   = out_err_q;

  // an accepted beat blocks the input until its result is committed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // scaler and divider never run at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(scale_stat.busy && div_stat.busy))
    else $error("scaler and divider busy together");

  // a divide error always carries a zero limb
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_error_o) |-> (result_limb_o == '0))
    else $error("divide error with non-zero limb");

  // a finished beat with a free output register shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && !out_valid_q) |=> out_valid_o)
    else $error("finished beat not presented");

endmodule

[hw/rtl/dlasd_scale.sv]
// ----------------------------------------------------------------------------
// dlasd_scale: serial multiply by a power of ten
// Multiplies a held word by ten once per cycle, one decimal digit a step,
// until the digit count runs out.
// ----------------------------------------------------------------------------
module dlasd_scale (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dlasd_pkg::dlasd_scale_cmd_t    cmd_i,
  input  logic [dlasd_pkg::WORD_W-1:0]   value_i,
  output dlasd_pkg::dlasd_unit_stat_t    stat_o,
  output logic [dlasd_pkg::DIV_W-1:0]    prod_o
);
  import dlasd_pkg::*;

  logic               run_q, run_d;
  logic [DIGIT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]   acc_q, acc_d;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    if (cmd_i.start) begin
      run_d = 1'b1;
      cnt_d = cmd_i.digits;
      acc_d = {{(DIV_W-WORD_W){1'b0}}, value_i};
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        acc_d = (acc_q << 3) + (acc_q << 1);
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      acc_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = run_q && (cnt_q == '0);
  assign prod_o      = acc_q;

endmodule

[hw/rtl/dlasd_div.sv]
// ----------------------------------------------------------------------------
// dlasd_div: bit-serial restoring divider
// Divides a left-aligned dividend by a word, one quotient bit per cycle,
// keeping the low word of the quotient and the exact remainder.
// ----------------------------------------------------------------------------
module dlasd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dlasd_pkg::dlasd_div_cmd_t      cmd_i,
  input  logic [dlasd_pkg::DIV_W-1:0]    dividend_i,
  input  logic [dlasd_pkg::WORD_W-1:0]   divisor_i,
  output dlasd_pkg::dlasd_unit_stat_t    stat_o,
  output logic [dlasd_pkg::WORD_W-1:0]   quot_o,
  output logic [dlasd_pkg::WORD_W-1:0]   rem_o
);
  import dlasd_pkg::*;

  localparam int CntW = $clog2(DIV_W + 1);

  logic              run_q, run_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DIV_W-1:0]  dsh_q, dsh_d;
  logic [WORD_W-1:0] dvs_q, dvs_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quot_q, quot_d;
  logic [WORD_W:0]   trial;
  logic [WORD_W+1:0] diff;

  // partial remainder stays below the divisor, so one compare per bit suffices
  assign trial = {rem_q, dsh_q[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    dsh_d  = dsh_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (cmd_i.start) begin
      run_d  = 1'b1;
      cnt_d  = cmd_i.half ? CntW'(WORD_W) : CntW'(DIV_W);
      dsh_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quot_d = '0;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        dsh_d  = dsh_q << 1;
        cnt_d  = cnt_q - 1'b1;
        quot_d = {quot_q[WORD_W-2:0], ~diff[WORD_W+1]};
        rem_d  = diff[WORD_W+1] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      dsh_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      dsh_q  <= dsh_d;
      dvs_q  <= dvs_d;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = run_q && (cnt_q == '0);
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

[bench/dlasd_result_checker.sv]
// ----------------------------------------------------------------------------
// dlasd_result_checker: result predictor and scoreboard for the limb unit
// Watches the configuration, input and result channels of the decimal limb
// add/sub/divide block and works out every result limb from its own copy of
// the carry, remainder, zero flag and digit count. Compares each result beat
// field by field with the oldest expected limb and counts the mismatches.
// ----------------------------------------------------------------------------
module dlasd_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlasd_pkg::DIGIT_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    req_type_i,
  input  logic [dlasd_pkg::WORD_W-1:0]  operand_a_i,
  input  logic [dlasd_pkg::WORD_W-1:0]  operand_b_i,
  input  logic                          int_part_i,
  input  logic                          last_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [dlasd_pkg::WORD_W-1:0]  result_limb_i,
  input  logic                          result_last_i,
  input  logic                          all_zero_i,
  input  logic                          div_error_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import dlasd_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] limb;
    logic              last;
    logic              zero;
    logic              err;
  } limb_result_t;

  logic [DIGIT_W-1:0] digits_q;
  logic               carry_q;
  logic [WORD_W-1:0]  rem_q;
  logic               zero_q;
  limb_result_t       expected_limbs [$];
  int                 mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    $display("%0t: mismatch on %s, got %0h, want %0h", $time, what, got, want);
  endtask

  // Work out one result limb and advance the running state.
  function automatic limb_result_t predict_limb(input logic [1:0] op_bits,
                                                input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic ip, input logic lst);
    dlasd_op_e          op;
    logic [DIGIT_W-1:0] k;
    logic [DIV_W-1:0]   base;
    logic [DIV_W-1:0]   wide;
    logic               active;
    limb_result_t       r;
    op     = dlasd_op_e'(op_bits);
    k      = (digits_q == 0 || digits_q > MAX_LIMB_DIGITS) ? DIGIT_W'(FALLBACK_DIGITS)
                                                          : digits_q;
    base   = 64'd1;
    for (int i = 0; i < k; i++) base = base * 64'd10;
    r      = '0;
    active = 1'b1;
    case (op)
      OP_ADD: begin
        wide = {32'd0, a} + {32'd0, b} + {63'd0, carry_q};
        if (ip || wide < base) begin
          r.limb  = wide[WORD_W-1:0];
          carry_q = 1'b0;
        end else begin
          r.limb  = WORD_W'(wide - base);
          carry_q = 1'b1;
        end
      end
      OP_SUB: begin
        if (!ip && ({32'd0, a} < {32'd0, b} + {63'd0, carry_q})) begin
          wide    = {32'd0, a} + base - {32'd0, b} - {63'd0, carry_q};
          r.limb  = wide[WORD_W-1:0];
          carry_q = 1'b1;
        end else begin
          r.limb  = a - b - WORD_W'(carry_q);
          carry_q = 1'b0;
        end
      end
      OP_DIV: begin
        if (b == '0) begin
          r.err = 1'b1;
          rem_q = '0;
        end else begin
          // integer part opens a fresh division, held remainder is dropped
          wide   = ip ? {32'd0, a} : {32'd0, a} + {32'd0, rem_q} * base;
          r.limb = WORD_W'(wide / {32'd0, b});
          rem_q  = WORD_W'(wide % {32'd0, b});
        end
      end
      default: active = 1'b0;
    endcase
    if (active && r.limb != '0) zero_q = 1'b0;
    r.last = lst;
    r.zero = zero_q;
    if (lst) begin
      carry_q = 1'b0;
      rem_q   = '0;
      zero_q  = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    limb_result_t want;
    if (!rst_ni) begin
      digits_q = DIGIT_W'(RESET_DIGITS);
      carry_q  = 1'b0;
      rem_q    = '0;
      zero_q   = 1'b1;
      expected_limbs.delete();
      pending_o <= 0;
    end else begin
      // check the result beat first: a beat taken at this edge cannot be out yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_limbs.size() == 0) begin
          report_mismatch("unexpected result", result_limb_i, '0);
        end else begin
          want = expected_limbs.pop_front();
          if (result_limb_i !== want.limb)
            report_mismatch("result_limb", result_limb_i, want.limb);
          if (result_last_i !== want.last)
            report_mismatch("result_last", WORD_W'(result_last_i), WORD_W'(want.last));
          if (all_zero_i !== want.zero)
            report_mismatch("all_zero", WORD_W'(all_zero_i), WORD_W'(want.zero));
          if (div_error_i !== want.err)
            report_mismatch("div_error", WORD_W'(div_error_i), WORD_W'(want.err));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_limbs.push_back(predict_limb(req_type_i, operand_a_i, operand_b_i,
                                              int_part_i, last_i));
      if (cfg_we_i) digits_q = cfg_wdata_i;
      pending_o <= expected_limbs.size();
    end
  end

endmodule

[bench/tb_decimal_limb_add_sub_div_top.sv]
// ----------------------------------------------------------------------------
// tb_decimal_limb_add_sub_div_top: stimulus and verdict for the limb unit
// Drives directed and random limb beats through the decimal add/sub/divide
// block under several digit counts, with bursty input and a stalling result
// side, and leaves prediction and comparison to the result checker.
// ----------------------------------------------------------------------------
module tb_decimal_limb_add_sub_div_top;
  import dlasd_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_BEATS   = 135;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [DIGIT_W-1:0]  cfg_wdata  = '0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [1:0]          req_type   = OP_ADD;
  logic [WORD_W-1:0]   operand_a  = '0;
  logic [WORD_W-1:0]   operand_b  = '0;
  logic                int_part   = 1'b0;
  logic                beat_last  = 1'b0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [WORD_W-1:0]   result_limb;
  logic                result_last;
  logic                all_zero;
  logic                div_error;

  int                  pending;
  int                  fail_count;

  // stimulus-side bookkeeping
  logic [WORD_W-1:0]   limb_base  = 32'd10000;
  int                  burst_left = 0;
  int                  beats_sent = 0;
  logic                hold_req   = 1'b0;
  logic                hold_done  = 1'b0;
  int                  hold_left  = 0;
  logic [15:0]         stall_cyc  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  decimal_limb_add_sub_div_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .operand_a_i   (operand_a),
    .operand_b_i   (operand_b),
    .int_part_i    (int_part),
    .last_i        (beat_last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_limb_o (result_limb),
    .result_last_o (result_last),
    .all_zero_o    (all_zero),
    .div_error_o   (div_error)
  );

  dlasd_result_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .req_type_i    (req_type),
    .operand_a_i   (operand_a),
    .operand_b_i   (operand_b),
    .int_part_i    (int_part),
    .last_i        (beat_last),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .result_limb_i (result_limb),
    .result_last_i (result_last),
    .all_zero_i    (all_zero),
    .div_error_i   (div_error),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // Result side: a stall pattern that steps through four modes in turn (free flow,
  // light, heavy, periodic), plus one long hold-off on request so that the
  // output register and the unit behind it fill and the input stalls.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      case (stall_cyc[9:8])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
        2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_cyc[3] & stall_cyc[1];
      endcase
    end
  end

  // Fractional limb: mostly below the modulus, with the edges and the
  // occasional out-of-range word mixed in.
  function automatic logic [WORD_W-1:0] pick_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return limb_base - 1;
      2:       return $urandom;
      default: return $urandom_range(0, limb_base - 1);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_divisor();
    case ($urandom_range(0, 15))
      0:                return '0;
      1:                return 32'd1;
      2:                return '1;
      3, 4, 5, 6, 7, 8: return $urandom_range(1, 1000);
      default:          return $urandom;
    endcase
  endfunction

  // Offer one beat and hold it until taken. Open a new burst, with a random
  // gap in front of it, whenever the current burst is used up.
  task automatic push_beat(input dlasd_op_e op, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b, input logic ip, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    req_type  <= op;
    operand_a <= a;
    operand_b <= b;
    int_part  <= ip;
    beat_last <= lst;
    do @(posedge clk); while (in_stall);
    burst_left--;
    beats_sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let the unit settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_digits(input logic [DIGIT_W-1:0] k);
    logic [DIGIT_W-1:0] eff;
    eff = (k == 0 || k > MAX_LIMB_DIGITS) ? DIGIT_W'(FALLBACK_DIGITS) : k;
    limb_base = 32'd1;
    for (int i = 0; i < eff; i++) limb_base = limb_base * 32'd10;
    cfg_wdata <= k;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One well-formed number: add/sub lowest limb first and integer part last,
  // divide integer part first. Some subtracts use equal operands so that the
  // whole result is zero; some divides change the divisor part-way through.
  task automatic send_number();
    dlasd_op_e         op;
    int                nfrac;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] divisor;
    logic              mirror;
    nfrac = $urandom_range(0, 4);
    case ($urandom_range(0, 2))
      0:       op = OP_ADD;
      1:       op = OP_SUB;
      default: op = OP_DIV;
    endcase
    if (op == OP_DIV) begin
      divisor = pick_divisor();
      push_beat(op, pick_word(), divisor, 1'b1, nfrac == 0);
      for (int i = 1; i <= nfrac; i++) begin
        if ($urandom_range(0, 7) == 0) divisor = pick_divisor();
        push_beat(op, pick_frac(), divisor, 1'b0, i == nfrac);
      end
    end else begin
      mirror = (op == OP_SUB) && ($urandom_range(0, 5) == 0);
      for (int i = 0; i < nfrac; i++) begin
        a = pick_frac();
        b = mirror ? a : pick_frac();
        push_beat(op, a, b, 1'b0, 1'b0);
      end
      a = pick_word();
      b = mirror ? a : pick_word();
      push_beat(op, a, b, 1'b1, 1'b1);
    end
  endtask

  // Mostly whole numbers; the rest are loose beats with any operation,
  // any operands and any position flags.
  task automatic random_phase(input int n);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0)
        push_beat(dlasd_op_e'($urandom_range(0, 3)), $urandom, $urandom,
                  1'($urandom), 1'($urandom));
      else
        send_number();
    end
  endtask

  initial begin : stimulus
    logic [DIGIT_W-1:0] digit_plan [7];
    digit_plan = '{4'd9, 4'd1, 4'd0, 4'd15, 4'd10, 4'd0, 4'd4};
    digit_plan[5] = DIGIT_W'($urandom_range(0, 15));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset digit count (modulus 10000).
    // carry out of the top fractional limb, integer part wraps to zero
    push_beat(OP_ADD, 32'd9999, 32'd1, 1'b0, 1'b0);
    push_beat(OP_ADD, '1, '0, 1'b1, 1'b1);
    // borrow into the integer part
    push_beat(OP_SUB, '0, 32'd1, 1'b0, 1'b0);
    push_beat(OP_SUB, '0, '0, 1'b1, 1'b1);
    // fractional operands far above the modulus
    push_beat(OP_ADD, '1, '1, 1'b0, 1'b0);
    push_beat(OP_ADD, 32'h1234_5678, 32'd1, 1'b1, 1'b1);
    push_beat(OP_SUB, '1, '0, 1'b0, 1'b0);
    push_beat(OP_SUB, '0, '1, 1'b0, 1'b0);
    push_beat(OP_SUB, '0, '0, 1'b1, 1'b1);
    // plain divide, last limb's dividend is wider than a word
    push_beat(OP_DIV, 32'd100, 32'd7, 1'b1, 1'b0);
    push_beat(OP_DIV, 32'd5000, 32'd7, 1'b0, 1'b0);
    push_beat(OP_DIV, '1, 32'd7, 1'b0, 1'b1);
    // zero divisor
    push_beat(OP_DIV, 32'd5, '0, 1'b1, 1'b0);
    push_beat(OP_DIV, 32'd3, '0, 1'b0, 1'b1);
    // divisor shrinks mid-number: quotient wider than a word
    push_beat(OP_DIV, '1, 32'hFFFF_FFFE, 1'b1, 1'b0);
    push_beat(OP_DIV, '1, 32'd1, 1'b0, 1'b1);
    // second integer part ignores the held remainder
    push_beat(OP_DIV, 32'd10, 32'd3, 1'b1, 1'b0);
    push_beat(OP_DIV, 32'd10, 32'd3, 1'b1, 1'b1);
    // unused operation code, alone and closing a number
    push_beat(OP_NONE, '1, '1, 1'b0, 1'b0);
    push_beat(OP_NONE, '0, '0, 1'b1, 1'b1);
    // all-zero number
    push_beat(OP_ADD, '0, '0, 1'b0, 1'b0);
    push_beat(OP_ADD, '0, '0, 1'b1, 1'b1);
    drain();

    // Random part, one phase per digit count; the long hold-off fires early
    // in the first phase while beats keep coming.
    hold_req <= 1'b1;
    random_phase(PHASE_BEATS);
    drain();
    foreach (digit_plan[i]) begin
      write_digits(digit_plan[i]);
      random_phase(PHASE_BEATS);
      drain();
    end

    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

endmodule
